// File: src/bounded_undo_redo_history_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the undo/redo history unit
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNDO_REDO_HISTORY_UNIT_ASSERT_SVH
`define BOUNDED_UNDO_REDO_HISTORY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BURH_ASSERT(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("check failed: condition");
`define BURH_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("check failed: next-cycle consequence");
`else
`define BURH_ASSERT(lbl, cond)
`define BURH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/burh_pkg.sv
// ----------------------------------------------------------------------------
// burh_pkg
// Shared types and constants of the undo/redo history unit.
// ----------------------------------------------------------------------------
package burh_pkg;

	localparam int OP_W       = 2;
	localparam int CFG_W      = 5;
	localparam int CUR_OUT_W  = 32;
	localparam int CNT_OUT_W  = 5;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_SAVE  = 2'd0,
		OP_UNDO  = 2'd1,
		OP_REDO  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // latch the beat and read both store tops
		logic exec;  // apply the operation and load the result register
	} cmd_t;

	typedef struct packed {
		logic                 error;
		logic [CNT_OUT_W-1:0] redo_count;
		logic [CNT_OUT_W-1:0] undo_count;
		logic                 has_current;
		logic [CUR_OUT_W-1:0] current_out;
	} result_t;

endpackage

// File: src/burh_controller.sv
// ----------------------------------------------------------------------------
// burh_controller
// Handshake control: accepts a beat, then applies it in the execute state once the
// result register is free.
// ----------------------------------------------------------------------------
`include "bounded_undo_redo_history_unit_assert.svh"

module burh_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output burh_pkg::cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd.load = s_tvalid & s_tready_q;
		cmd.exec = (state_q == ST_EXEC) & (~m_tvalid_q | m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result replaces one that leaves on the same edge.
			if (cmd.exec) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q    <= ST_EXEC;
						s_tready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q    <= ST_IDLE;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					s_tready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

	`BURH_ASSERT_NEXT(a_load_then_exec, cmd.load, state_q == ST_EXEC)
	`BURH_ASSERT_NEXT(a_exec_gives_result, cmd.exec, m_tvalid_q)
	`BURH_ASSERT(a_ready_tracks_idle, s_tready_q == (state_q == ST_IDLE))

endmodule

// File: src/burh_datapath.sv
// ----------------------------------------------------------------------------
// burh_datapath
// Undo ring, redo stack, current value, counters and the result register.
// ----------------------------------------------------------------------------
`include "bounded_undo_redo_history_unit_assert.svh"

module burh_datapath #(
	parameter int HISTORY_DEPTH = 16,
	parameter int DATA_WIDTH    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  burh_pkg::cmd_t               cmd,
	input  logic [burh_pkg::OP_W-1:0]    opcode,
	input  logic [DATA_WIDTH-1:0]        value_in,
	input  logic                         cfg_we,
	input  logic [burh_pkg::CFG_W-1:0]   cfg_wdata,
	output burh_pkg::result_t            result
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [AW-1:0] TOP_LAST  = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FILL_FULL = CW'(HISTORY_DEPTH);

	logic [DATA_WIDTH-1:0] undo_mem [HISTORY_DEPTH];
	logic [DATA_WIDTH-1:0] redo_mem [HISTORY_DEPTH];

	burh_pkg::op_t              op_q;
	logic [DATA_WIDTH-1:0]      val_q;
	logic [DATA_WIDTH-1:0]      undo_rd_q;
	logic [DATA_WIDTH-1:0]      redo_rd_q;
	logic [AW-1:0]              undo_top_q;
	logic [CW-1:0]              undo_fill_q;
	logic [CW-1:0]              redo_fill_q;
	logic [DATA_WIDTH-1:0]      cur_q;
	logic                       cur_valid_q;
	logic [burh_pkg::CFG_W-1:0] max_saving_q;
	burh_pkg::result_t          result_q;

	logic [AW-1:0]         top_inc;
	logic [AW-1:0]         top_dec;
	logic [AW-1:0]         redo_raddr;
	logic [CW-1:0]         fill_inc;
	logic [CW-1:0]         limit;
	logic [AW-1:0]         top_n;
	logic [CW-1:0]         fill_n;
	logic [CW-1:0]         rfill_n;
	logic [DATA_WIDTH-1:0] cur_n;
	logic                  valid_n;
	logic                  err_n;
	logic                  undo_we;
	logic                  redo_we;
	logic [63:0]           cur_wide;
	logic [63:0]           fill_wide;
	logic [63:0]           rfill_wide;

	// Effective undo limit: zero or anything above the depth means the depth.
	function automatic logic [CW-1:0] limit_of(input logic [burh_pkg::CFG_W-1:0] m);
		logic big;
		big = (32'(m) > 32'(HISTORY_DEPTH));
		if (m == '0 || big) begin
			return FILL_FULL;
		end
		return CW'(m);
	endfunction

	assign top_inc    = (undo_top_q == TOP_LAST) ? '0 : undo_top_q + 1'b1;
	assign top_dec    = (undo_top_q == '0) ? TOP_LAST : undo_top_q - 1'b1;
	assign redo_raddr = (redo_fill_q == '0) ? '0 : AW'(redo_fill_q - 1'b1);
	assign fill_inc   = (undo_fill_q < FILL_FULL) ? undo_fill_q + 1'b1 : undo_fill_q;
	assign limit      = limit_of(max_saving_q);

	always_comb begin
		top_n   = undo_top_q;
		fill_n  = undo_fill_q;
		rfill_n = redo_fill_q;
		cur_n   = cur_q;
		valid_n = cur_valid_q;
		err_n   = 1'b0;
		undo_we = 1'b0;
		redo_we = 1'b0;
		case (op_q)
			burh_pkg::OP_SAVE: begin
				rfill_n = '0;
				if (cur_valid_q) begin
					undo_we = 1'b1;
					top_n   = top_inc;
					fill_n  = (fill_inc > limit) ? limit : fill_inc;
				end
				cur_n   = val_q;
				valid_n = 1'b1;
			end
			burh_pkg::OP_UNDO: begin
				if (undo_fill_q == '0) begin
					err_n = 1'b1;
				end else begin
					if (cur_valid_q && redo_fill_q < FILL_FULL) begin
						redo_we = 1'b1;
						rfill_n = redo_fill_q + 1'b1;
					end
					top_n   = top_dec;
					fill_n  = undo_fill_q - 1'b1;
					cur_n   = undo_rd_q;
					valid_n = 1'b1;
				end
			end
			burh_pkg::OP_REDO: begin
				if (redo_fill_q == '0) begin
					err_n = 1'b1;
				end else begin
					// A redo pushes without trimming to the limit.
					if (cur_valid_q) begin
						undo_we = 1'b1;
						top_n   = top_inc;
						fill_n  = fill_inc;
					end
					rfill_n = redo_fill_q - 1'b1;
					cur_n   = redo_rd_q;
					valid_n = 1'b1;
				end
			end
			default: begin
				top_n   = '0;
				fill_n  = '0;
				rfill_n = '0;
				cur_n   = '0;
				valid_n = 1'b0;
			end
		endcase
		cur_wide   = 64'(cur_n);
		fill_wide  = 64'(fill_n);
		rfill_wide = 64'(rfill_n);
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && undo_we) begin
			undo_mem[undo_top_q] <= cur_q;
		end
		if (cmd.load) begin
			undo_rd_q <= undo_mem[top_dec];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && redo_we) begin
			redo_mem[AW'(redo_fill_q)] <= cur_q;
		end
		if (cmd.load) begin
			redo_rd_q <= redo_mem[redo_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= burh_pkg::op_t'(opcode);
			val_q <= value_in;
		end
		if (cmd.exec) begin
			result_q.current_out <= valid_n ? cur_wide[burh_pkg::CUR_OUT_W-1:0] : '0;
			result_q.has_current <= valid_n;
			result_q.undo_count  <= fill_wide[burh_pkg::CNT_OUT_W-1:0];
			result_q.redo_count  <= rfill_wide[burh_pkg::CNT_OUT_W-1:0];
			result_q.error       <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undo_top_q   <= '0;
			undo_fill_q  <= '0;
			redo_fill_q  <= '0;
			cur_q        <= '0;
			cur_valid_q  <= 1'b0;
			max_saving_q <= '0;
		end else begin
			if (cfg_we) begin
				max_saving_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				undo_top_q  <= top_n;
				undo_fill_q <= fill_n;
				redo_fill_q <= rfill_n;
				cur_q       <= cur_n;
				cur_valid_q <= valid_n;
			end else if (cfg_we) begin
				// Lowering the limit drops the oldest entries at once.
				if (undo_fill_q > limit_of(cfg_wdata)) begin
					undo_fill_q <= limit_of(cfg_wdata);
				end
			end
		end
	end

	assign result = result_q;

	`BURH_ASSERT(a_fill_bound, ({1'b0, undo_fill_q} + {1'b0, redo_fill_q}) <= (CW + 1)'(HISTORY_DEPTH))
	`BURH_ASSERT(a_empty_without_current, cur_valid_q || (undo_fill_q == '0 && redo_fill_q == '0))

endmodule

// File: src/bounded_undo_redo_history_unit.sv
// ----------------------------------------------------------------------------
// bounded_undo_redo_history_unit
// Bounded undo/redo history with a stream input, a stream output and one
// configuration register (max_saving).
// ----------------------------------------------------------------------------
// One result beat follows every input beat. An operation has a load step and an
// execute step: the cycle of acceptance reads both store tops through their
// registered read ports, and the execute state then applies the operation and
// loads the result register. No new beat is accepted before that execute step.
// A new beat is accepted while the previous result still waits on the output;
// the execute step waits only if that result has not been taken. The stores need
// no clearing pass after reset: the fill counts guard every read. Write
// max_saving only while the block is idle; a lowered limit trims the undo
// history at once.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history_unit #(
	parameter int HISTORY_DEPTH = 16,
	parameter int DATA_WIDTH    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// value_in [DATA_WIDTH-1:0], zero padding above
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
	// opcode [1:0]
	input  logic [burh_pkg::OP_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// current_out [31:0], undo_count [36:32], redo_count [41:37], zeros above
	output logic [burh_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// has_current [0], error [1]
	output logic [burh_pkg::OUT_TUSER_W-1:0]   m_tuser,
	input  logic                               cfg_we,
	input  logic [burh_pkg::CFG_W-1:0]         cfg_wdata
);

	burh_pkg::cmd_t    cmd;
	burh_pkg::result_t result;

	burh_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	burh_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.DATA_WIDTH    (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (s_tuser),
		.value_in  (s_tdata[DATA_WIDTH-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	assign m_tdata = burh_pkg::OUT_TDATA_W'({result.redo_count, result.undo_count,
		result.current_out});
	assign m_tuser = {result.error, result.has_current};

endmodule

// File: bench/tb_bounded_undo_redo_history_unit.sv
// ----------------------------------------------------------------------------
// tb_bounded_undo_redo_history_unit
// Self-checking bench for the undo/redo history unit. Operations are streamed
// in through the slave side, and an in-bench history tracker predicts every
// result beat. The run steps through several max_saving limits, with random
// idling on both sides in every phase but the last.
// ----------------------------------------------------------------------------
module tb_bounded_undo_redo_history_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_DEPTH = 16;
	localparam int VAL_W      = 32;

	localparam logic [burh_pkg::CFG_W-1:0] PHASE_LIMITS [9] =
		'{5'd16, 5'd1, 5'd17, 5'd31, 5'd2, 5'd0, 5'd5, 5'd3, 5'd0};
	localparam int IDLE_PCTS [4] = '{0, 10, 30, 60};

	typedef struct {
		burh_pkg::op_t    op;
		logic [VAL_W-1:0] value;
	} hist_op_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [VAL_W-1:0]                 s_tdata   = '0;
	logic [burh_pkg::OP_W-1:0]        s_tuser   = burh_pkg::OP_SAVE;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [burh_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [burh_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic                             cfg_we    = 1'b0;
	logic [burh_pkg::CFG_W-1:0]       cfg_wdata = '0;

	bounded_undo_redo_history_unit #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.DATA_WIDTH   (VAL_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// History tracker state.
	logic [VAL_W-1:0]           undo_ring [HIST_DEPTH];
	logic [3:0]                 undo_wr_slot = '0;
	logic [4:0]                 undo_depth   = '0;
	logic [VAL_W-1:0]           redo_stack [HIST_DEPTH];
	logic [4:0]                 redo_depth   = '0;
	logic [VAL_W-1:0]           cur_val      = '0;
	logic                       cur_held     = 1'b0;
	logic [burh_pkg::CFG_W-1:0] undo_limit   = '0;

	hist_op_t          pending_ops [$];
	burh_pkg::result_t expected_results [$];
	hist_op_t          next_op;

	logic in_beat_taken = 1'b0;
	bit   idling_on     = 1'b1;
	int   src_idle_pct  = 0;
	int   snk_stall_pct = 0;
	int   src_gap       = 0;
	int   snk_gap       = 0;

	int   fail_count    = 0;
	int   op_tally [4]  = '{default: 0};
	int   err_beats     = 0;
	int   result_beats  = 0;
	int   deepest_undo  = 0;
	int   deepest_redo  = 0;
	int   limit_writes  = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("%0t: timeout, %0d operations still queued, %0d results outstanding",
			$realtime, pending_ops.size(), expected_results.size());
		$display("bounded_undo_redo_history_unit verification failed");
		$finish;
	end

	// The limit keeps the newest entries: they sit just below the write slot,
	// so cutting the depth drops the oldest ones.
	function automatic void trim_undo();
		logic [4:0] cap;
		cap = (undo_limit == 0 || undo_limit > HIST_DEPTH) ? 5'(HIST_DEPTH) : undo_limit;
		if (undo_depth > cap)
			undo_depth = cap;
	endfunction

	function automatic void push_undo(logic [VAL_W-1:0] v);
		undo_ring[undo_wr_slot] = v;
		undo_wr_slot = undo_wr_slot + 4'd1;
		if (undo_depth < HIST_DEPTH)
			undo_depth = undo_depth + 5'd1;
	endfunction

	function automatic burh_pkg::result_t history_apply(burh_pkg::op_t op,
		logic [VAL_W-1:0] v);
		burh_pkg::result_t r;
		r.error = 1'b0;
		case (op)
			burh_pkg::OP_SAVE: begin
				redo_depth = '0;
				if (cur_held) begin
					push_undo(cur_val);
					trim_undo();
				end
				cur_val  = v;
				cur_held = 1'b1;
			end
			burh_pkg::OP_UNDO: begin
				if (undo_depth == 0) begin
					r.error = 1'b1;
				end else begin
					if (cur_held && redo_depth < HIST_DEPTH) begin
						redo_stack[redo_depth] = cur_val;
						redo_depth = redo_depth + 5'd1;
					end
					undo_wr_slot = undo_wr_slot - 4'd1;
					undo_depth   = undo_depth - 5'd1;
					cur_val      = undo_ring[undo_wr_slot];
					cur_held     = 1'b1;
				end
			end
			burh_pkg::OP_REDO: begin
				if (redo_depth == 0) begin
					r.error = 1'b1;
				end else begin
					if (cur_held)
						push_undo(cur_val);
					redo_depth = redo_depth - 5'd1;
					cur_val    = redo_stack[redo_depth];
					cur_held   = 1'b1;
				end
			end
			default: begin
				undo_depth   = '0;
				undo_wr_slot = '0;
				redo_depth   = '0;
				cur_val      = '0;
				cur_held     = 1'b0;
			end
		endcase
		r.current_out = cur_held ? cur_val : '0;
		r.has_current = cur_held;
		r.undo_count  = undo_depth;
		r.redo_count  = redo_depth;
		return r;
	endfunction

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
		end
	endtask

	// Sender: holds each beat until it is taken, then may insert an idle burst.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_beat_taken)) begin
			if (src_gap != 0) begin
				src_gap  <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 99) < src_idle_pct) begin
				src_gap  <= $urandom_range(0, 9);
				s_tvalid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				next_op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_op.op;
				s_tdata  <= next_op.value;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (snk_gap != 0) begin
			snk_gap  <= snk_gap - 1;
			m_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 99) < snk_stall_pct) begin
			snk_gap  <= $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: checks result beats, then predicts for the input beat taken here.
	always @(posedge clk) begin
		burh_pkg::result_t want;
		in_beat_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			result_beats++;
			if (expected_results.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with nothing expected, tdata 0x%0h tuser 0x%0h",
					$realtime, m_tdata, m_tuser);
			end else begin
				want = expected_results.pop_front();
				cmp_field("current_out", want.current_out, m_tdata[31:0]);
				cmp_field("undo_count", want.undo_count, m_tdata[36:32]);
				cmp_field("redo_count", want.redo_count, m_tdata[41:37]);
				cmp_field("has_current", want.has_current, m_tuser[0]);
				cmp_field("error", want.error, m_tuser[1]);
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			want = history_apply(burh_pkg::op_t'(s_tuser), s_tdata);
			expected_results.push_back(want);
			op_tally[s_tuser]++;
			if (want.error)
				err_beats++;
			if (want.undo_count > deepest_undo)
				deepest_undo = want.undo_count;
			if (want.redo_count > deepest_redo)
				deepest_redo = want.redo_count;
		end
	end

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1 << $urandom_range(0, VAL_W - 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(burh_pkg::op_t op, logic [VAL_W-1:0] v);
		hist_op_t it;
		it.op    = op;
		it.value = v;
		pending_ops.push_back(it);
	endtask

	// Runs of saves build the history up, runs of undos and redos walk it and
	// overshoot into the empty-stack errors; clears are kept rare.
	task automatic queue_random_ops(int n_items, int clear_pct);
		int left;
		int run;
		int pick;
		burh_pkg::op_t op;
		left = n_items;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			run  = 1;
			if (pick < clear_pct) begin
				op = burh_pkg::OP_CLEAR;
			end else if (pick < 50) begin
				op  = burh_pkg::OP_SAVE;
				run = $urandom_range(1, 20);
			end else if (pick < 75) begin
				op  = burh_pkg::OP_UNDO;
				run = $urandom_range(1, 18);
			end else if (pick < 92) begin
				op  = burh_pkg::OP_REDO;
				run = $urandom_range(1, 18);
			end else begin
				op = burh_pkg::op_t'($urandom_range(0, 3));
			end
			if (run > left)
				run = left;
			repeat (run) queue_op(op, rand_value());
			left -= run;
		end
	endtask

	task automatic wait_history_idle();
		wait (pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_max_saving(logic [burh_pkg::CFG_W-1:0] v);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		undo_limit = v;
		trim_undo();
		limit_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, bit extremes, walking the stacks both ways,
		// redo cleared by a save, and pops after a clear.
		queue_op(burh_pkg::OP_UNDO, 32'h0);
		queue_op(burh_pkg::OP_REDO, 32'hFFFF_FFFF);
		queue_op(burh_pkg::OP_CLEAR, 32'h0);
		queue_op(burh_pkg::OP_SAVE, 32'h0000_0000);
		queue_op(burh_pkg::OP_SAVE, 32'hFFFF_FFFF);
		queue_op(burh_pkg::OP_SAVE, 32'hAAAA_AAAA);
		queue_op(burh_pkg::OP_SAVE, 32'h5555_5555);
		queue_op(burh_pkg::OP_UNDO, 32'h0);
		queue_op(burh_pkg::OP_UNDO, 32'h0);
		queue_op(burh_pkg::OP_REDO, 32'h0);
		queue_op(burh_pkg::OP_REDO, 32'h0);
		queue_op(burh_pkg::OP_REDO, 32'h0);
		queue_op(burh_pkg::OP_SAVE, 32'h0000_0001);
		queue_op(burh_pkg::OP_REDO, 32'h0);
		repeat (5) queue_op(burh_pkg::OP_UNDO, 32'h0);
		queue_op(burh_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		queue_op(burh_pkg::OP_UNDO, 32'h0);
		queue_op(burh_pkg::OP_SAVE, 32'h8000_0000);
		queue_op(burh_pkg::OP_REDO, 32'h0);
		wait_history_idle();

		// Each limit gets a phase; lowering it after a deep phase trims the
		// history at once. The second half of each phase starts from idle.
		for (int p = 0; p < 9; p++) begin
			write_max_saving(PHASE_LIMITS[p]);
			if (p == 8) begin
				idling_on = 1'b0;
			end else begin
				src_idle_pct  = IDLE_PCTS[$urandom_range(0, 3)];
				snk_stall_pct = IDLE_PCTS[$urandom_range(0, 3)];
			end
			queue_random_ops(72, (p % 3 == 0) ? 4 : 1);
			wait_history_idle();
			queue_random_ops(72, 2);
			wait_history_idle();
		end

		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d expected results never arrived", $realtime,
				expected_results.size());
		end
		$display("Ran %0d saves, %0d undos, %0d redos and %0d clears;",
			op_tally[burh_pkg::OP_SAVE], op_tally[burh_pkg::OP_UNDO],
			op_tally[burh_pkg::OP_REDO], op_tally[burh_pkg::OP_CLEAR]);
		$display("%0d result beats, %0d with error; max_saving written %0d times; %s %0d, %s %0d.",
			result_beats, err_beats, limit_writes, "undo history reached", deepest_undo,
			"redo stack", deepest_redo);
		if (fail_count == 0) begin
			$display("bounded_undo_redo_history_unit verification clean");
		end else begin
			$display("bounded_undo_redo_history_unit verification failed");
		end
		$finish;
	end

endmodule
